// ----- hw/rtl/sph_density_double_cosine_macros.svh -----
// assertion macros shared by the checker of the density block
`ifndef SPH_DENSITY_DOUBLE_COSINE_MACROS_SVH
`define SPH_DENSITY_DOUBLE_COSINE_MACROS_SVH

// concurrent check on aclk, quiet while aresetn is low
`define SDC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// concurrent check on aclk that also holds during reset
`define SDC_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ----- hw/rtl/sdc_pkg.sv -----
// shared types, widths and constants of the density block
`default_nettype none

package sdc_pkg;

    localparam int MAX_PARTICLES_DEF = 64;

    localparam int IDX_W    = 6;
    localparam int POS_W    = 32;
    localparam int MASS_W   = 24;
    localparam int DENS_W   = 32;
    localparam int H_W      = 24;
    localparam int K_W      = 20;
    localparam int KHQ_W    = 28;
    localparam int KHQ2_W   = 56;
    localparam int D2_W     = 48;
    localparam int SQ_STEPS = 24;
    localparam int U_W      = 16;
    localparam int P_W      = 31;
    localparam int T2_W     = 30;
    localparam int NUM_W    = 57;
    localparam int FQ_W     = 33;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 24;
    localparam int S_DATA_W   = 88;
    localparam int M_DATA_W   = 40;

    localparam logic [H_W-1:0] H_RESET = 24'd393216;
    localparam logic [K_W-1:0] K_RESET = 20'd78643;

    // cosine series coefficients, Q1.30
    localparam logic [P_W-1:0] Q30_ONE = 31'd1073741824;
    localparam logic [P_W-1:0] COS_C1  = 31'd1324675880;
    localparam logic [P_W-1:0] COS_C2  = 31'd272375560;
    localparam logic [P_W-1:0] COS_C3  = 31'd22401997;
    localparam logic [P_W-1:0] COS_C4  = 31'd987038;
    localparam logic [P_W-1:0] COS_C5  = 31'd27061;
    localparam logic [P_W-1:0] COS_C6  = 31'd506;
    localparam logic [27:0]    SIGMA_Q30 = 28'd247872871;

    localparam logic [DENS_W-1:0] DENS_MAX = 32'hFFFF_FFFF;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_KERNEL_RADIUS = 1'b0,
        REG_COS_SUPPORT   = 1'b1
    } cfg_reg_t;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_RUN,
        ST_DRAIN
    } seq_state_t;

    // per pair control travelling down the chain
    typedef struct packed {
        logic             zero;
        logic             sat;
        logic             rowend;
        logic             lastrow;
        logic [IDX_W-1:0] idx;
    } tag_t;

    typedef struct packed {
        logic [MASS_W-1:0] mass;
        tag_t              tag;
    } mtag_t;

endpackage

`default_nettype wire

// ----- hw/rtl/sdc_ram.sv -----
// generic single write, single read ram with registered read
`default_nettype none

module sdc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/sdc_sqrt_cell.sv -----
// one bit step of the integer square root chain
`default_nettype none

module sdc_sqrt_cell #(
    parameter int VW    = 48,
    parameter int SHIFT = 0,
    parameter int PW    = 8
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          en,
    input  wire logic          in_vld,
    input  wire logic [VW-1:0] in_val,
    input  wire logic [VW-1:0] in_res,
    input  wire logic [PW-1:0] in_pay,
    output logic               out_vld,
    output logic      [VW-1:0] out_val,
    output logic      [VW-1:0] out_res,
    output logic      [PW-1:0] out_pay
);

    localparam logic [VW-1:0] BIT = {{(VW-1){1'b0}}, 1'b1} << SHIFT;

    logic [VW:0]   trial;
    logic          fits;
    logic [VW-1:0] val_next;
    logic [VW-1:0] res_next;

    // trial subtract of res + bit
    always_comb begin
        trial    = {1'b0, in_res} + {1'b0, BIT};
        fits     = {1'b0, in_val} >= trial;
        val_next = fits ? (in_val - trial[VW-1:0]) : in_val;
        res_next = fits ? ((in_res >> 1) + BIT) : (in_res >> 1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld <= 1'b0;
        end else if (en) begin
            out_vld <= in_vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            out_val <= val_next;
            out_res <= res_next;
            out_pay <= in_pay;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/sdc_div_cell.sv -----
// one quotient bit of a restoring division chain
`default_nettype none

module sdc_div_cell #(
    parameter int DW = 28,
    parameter int NW = 16,
    parameter int QW = 16,
    parameter int PW = 8
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          en,
    input  wire logic [DW-1:0] divisor,
    input  wire logic          in_vld,
    input  wire logic [DW-1:0] in_rem,
    input  wire logic [NW-1:0] in_num,
    input  wire logic [QW-1:0] in_q,
    input  wire logic [PW-1:0] in_pay,
    output logic               out_vld,
    output logic      [DW-1:0] out_rem,
    output logic      [NW-1:0] out_num,
    output logic      [QW-1:0] out_q,
    output logic      [PW-1:0] out_pay
);

    logic [DW:0]   part;
    logic [DW:0]   diff;
    logic          fits;
    logic [DW-1:0] rem_next;

    // shift in the next numerator bit and try the divisor
    always_comb begin
        part     = {in_rem, in_num[NW-1]};
        diff     = part - {1'b0, divisor};
        fits     = part >= {1'b0, divisor};
        rem_next = fits ? diff[DW-1:0] : part[DW-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld <= 1'b0;
        end else if (en) begin
            out_vld <= in_vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            out_rem <= rem_next;
            out_num <= in_num << 1;
            out_q   <= {in_q[QW-2:0], fits};
            out_pay <= in_pay;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/sdc_horner_cell.sv -----
// one clamped horner step of the cosine series
`default_nettype none

module sdc_horner_cell
    import sdc_pkg::*;
#(
    parameter logic [P_W-1:0] COEF = '0,
    parameter int             PW   = 8
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            en,
    input  wire logic            in_vld,
    input  wire logic [P_W-1:0]  in_p,
    input  wire logic [T2_W-1:0] in_t2,
    input  wire logic [PW-1:0]   in_pay,
    output logic                 out_vld,
    output logic      [P_W-1:0]  out_p,
    output logic      [T2_W-1:0] out_t2,
    output logic      [PW-1:0]   out_pay
);

    logic [P_W+T2_W-1:0] prod;
    logic [P_W-1:0]      scaled;
    logic [P_W-1:0]      p_next;

    // p = coef - p * t2, floored at zero
    always_comb begin
        prod   = in_p * in_t2;
        scaled = prod[P_W+T2_W-1:30];
        p_next = (scaled > COEF) ? '0 : (COEF - scaled);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld <= 1'b0;
        end else if (en) begin
            out_vld <= in_vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            out_p   <= p_next;
            out_t2  <= in_t2;
            out_pay <= in_pay;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/sph_density_double_cosine.sv -----
// one pair enters the cell chain a cycle while no result is stalled by backpressure;
// the pair rate is set by the single read port of each particle store
// loading takes one cycle per particle; results stall the whole chain on backpressure
// reset: clears sequencer, valid bits and configuration; particle stores stay undefined
`default_nettype none

module sph_density_double_cosine
    import sdc_pkg::*;
#(
    parameter int MAX_PARTICLES = MAX_PARTICLES_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // pos_x [31:0], pos_y [63:32], mass [87:64]
    input  wire logic [S_DATA_W-1:0]   s_tdata,
    input  wire logic                  s_tlast,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // particle_index [5:0], density [37:6], zero fill [39:38]
    output logic      [M_DATA_W-1:0]   m_tdata,
    output logic                       m_tlast
);

    localparam int AW = $clog2(MAX_PARTICLES);
    localparam int CW = $clog2(MAX_PARTICLES + 1);
    localparam int MP = $bits(mtag_t);
    localparam int TP = $bits(tag_t);

    // configuration and derived constants
    logic [H_W-1:0]    h_reg;
    logic [K_W-1:0]    k_reg;
    logic [KHQ_W-1:0]  khq_reg;
    logic [KHQ2_W-1:0] khq2_reg;
    logic [D2_W-1:0]   hh_reg;
    logic [H_W+K_W-1:0] kh_prod;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            h_reg <= H_RESET;
            k_reg <= K_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_KERNEL_RADIUS: h_reg <= cfg_wdata[H_W-1:0];
                REG_COS_SUPPORT:   k_reg <= cfg_wdata[K_W-1:0];
                default: ;
            endcase
        end
    end

    assign kh_prod = k_reg * h_reg;

    always_ff @(posedge aclk) begin
        khq_reg  <= kh_prod[H_W+K_W-1:16];
        khq2_reg <= khq_reg * khq_reg;
        hh_reg   <= h_reg * h_reg;
    end

    // sequencer
    seq_state_t    state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] n_reg, n_next;
    logic [AW-1:0] i_reg, i_next;
    logic [AW-1:0] j_reg, j_next;
    logic          adv;
    logic          s_acc;
    logic          store_wr;
    logic          issue;
    logic          j_end;
    logic          i_end;
    logic          last_out;

    assign adv      = !m_tvalid || m_tready;
    assign s_acc    = s_tvalid && s_tready;
    assign store_wr = s_acc && (count_reg < CW'(MAX_PARTICLES));
    assign j_end    = CW'(j_reg) == (n_reg - CW'(1));
    assign i_end    = CW'(i_reg) == (n_reg - CW'(1));
    assign last_out = m_tvalid && m_tready && m_tlast;

    // next state
    always_comb begin
        state_next = state_reg;
        count_next = count_reg;
        n_next     = n_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        unique case (state_reg)
            ST_LOAD: begin
                if (store_wr) begin
                    count_next = count_reg + CW'(1);
                end
                if (s_acc && s_tlast) begin
                    n_next     = store_wr ? (count_reg + CW'(1)) : count_reg;
                    count_next = '0;
                    i_next     = '0;
                    j_next     = '0;
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                if (adv) begin
                    if (j_end) begin
                        j_next = '0;
                        if (i_end) begin
                            state_next = ST_DRAIN;
                        end else begin
                            i_next = i_reg + AW'(1);
                        end
                    end else begin
                        j_next = j_reg + AW'(1);
                    end
                end
            end
            ST_DRAIN: begin
                if (last_out) begin
                    state_next = ST_LOAD;
                end
            end
            default: state_next = ST_LOAD;
        endcase
    end

    // sequencer outputs
    always_comb begin
        s_tready = 1'b0;
        issue    = 1'b0;
        unique case (state_reg)
            ST_LOAD:  s_tready = 1'b1;
            ST_RUN:   issue    = 1'b1;
            ST_DRAIN: ;
            default:  ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD;
            count_reg <= '0;
            n_reg     <= '0;
            i_reg     <= '0;
            j_reg     <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            n_reg     <= n_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
        end
    end

    // particle stores: one read at row i, one at column j
    logic [2*POS_W-1:0]        rdi;
    logic [2*POS_W+MASS_W-1:0] rdj;

    sdc_ram #(.WIDTH(2*POS_W), .DEPTH(MAX_PARTICLES)) u_ram_i (
        .aclk    (aclk),
        .wr_en   (store_wr),
        .wr_addr (count_reg[AW-1:0]),
        .wr_data (s_tdata[2*POS_W-1:0]),
        .rd_en   (adv),
        .rd_addr (i_reg),
        .rd_data (rdi)
    );

    sdc_ram #(.WIDTH(2*POS_W+MASS_W), .DEPTH(MAX_PARTICLES)) u_ram_j (
        .aclk    (aclk),
        .wr_en   (store_wr),
        .wr_addr (count_reg[AW-1:0]),
        .wr_data (s_tdata[2*POS_W+MASS_W-1:0]),
        .rd_en   (adv),
        .rd_addr (j_reg),
        .rd_data (rdj)
    );

    // front stages: differences, range check, squares
    tag_t               tag_issue;
    tag_t               tag1_reg, tag2_reg, tag3_reg;
    mtag_t              pay4_reg, pay5_reg, pay6_reg;
    mtag_t              payq1_reg, payq2_reg, payq3_reg, payq4_reg;
    tag_t               tagq5_reg;
    tag_t               tag3_next;
    mtag_t              pay4_next, pay5_next;
    tag_t               tagq5_next;
    logic               v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg;
    logic               vq1_reg, vq2_reg, vq3_reg, vq4_reg, vq5_reg;
    logic signed [POS_W:0] dx_s, dy_s;
    logic [POS_W:0]     adx, ady;
    logic [POS_W:0]     adx2_reg, ady2_reg;
    logic [MASS_W-1:0]  m2_reg, m3_reg;
    logic               far;
    logic [D2_W-1:0]    dx2_3_reg, dy2_3_reg;
    logic [D2_W:0]      d2_sum;
    logic [D2_W-1:0]    d2_4_reg;

    always_comb begin
        tag_issue.zero    = (i_reg == j_reg);
        tag_issue.sat     = 1'b0;
        tag_issue.rowend  = j_end;
        tag_issue.lastrow = i_end;
        tag_issue.idx     = IDX_W'(i_reg);
    end

    always_comb begin
        dx_s = $signed({rdi[POS_W-1], rdi[POS_W-1:0]})
             - $signed({rdj[POS_W-1], rdj[POS_W-1:0]});
        dy_s = $signed({rdi[2*POS_W-1], rdi[2*POS_W-1:POS_W]})
             - $signed({rdj[2*POS_W-1], rdj[2*POS_W-1:POS_W]});
        adx  = dx_s[POS_W] ? (POS_W+1)'(-dx_s) : dx_s;
        ady  = dy_s[POS_W] ? (POS_W+1)'(-dy_s) : dy_s;
        far  = (adx2_reg >= {{(POS_W+1-H_W){1'b0}}, h_reg})
            || (ady2_reg >= {{(POS_W+1-H_W){1'b0}}, h_reg});
        d2_sum = {1'b0, dx2_3_reg} + {1'b0, dy2_3_reg};
    end

    // sqrt chain ports
    logic            sq_v   [SQ_STEPS+1];
    logic [D2_W-1:0] sq_val [SQ_STEPS+1];
    logic [D2_W-1:0] sq_res [SQ_STEPS+1];
    logic [MP-1:0]   sq_pay [SQ_STEPS+1];
    mtag_t           sq_out;

    // u division chain ports
    logic             ud_v   [U_W+1];
    logic [KHQ_W-1:0] ud_rem [U_W+1];
    logic [U_W-1:0]   ud_num [U_W+1];
    logic [U_W-1:0]   ud_q   [U_W+1];
    logic [MP-1:0]    ud_pay [U_W+1];
    logic [KHQ_W-1:0] rem5_reg;
    logic [H_W-1:0]   r_root;

    // horner chain ports
    logic            hn_v   [7];
    logic [P_W-1:0]  hn_p   [7];
    logic [T2_W-1:0] hn_t2  [7];
    logic [MP-1:0]   hn_pay [7];
    logic [T2_W-1:0] t2_6_reg;
    logic [2*U_W-1:0] u_sq;

    localparam logic [P_W-1:0] HN_COEF [6] = '{COS_C5, COS_C4, COS_C3, COS_C2, COS_C1, Q30_ONE};

    // tail stages
    logic [2*P_W-1:0]   cq_sq, cq2_sq;
    logic [61:0]        fs_prod;
    logic [P_W-1:0]     cq2_reg;
    logic [33:0]        f_reg;
    logic [P_W-1:0]     a_reg;
    logic [MASS_W+P_W-1:0] ma_prod;
    logic [NUM_W-1:0]   num_reg;
    logic [KHQ2_W-1:0]  fd_rem0_reg;
    logic [FQ_W-1:0]    fd_num0_reg;

    // final division chain ports
    logic              fd_v   [FQ_W+1];
    logic [KHQ2_W-1:0] fd_rem [FQ_W+1];
    logic [FQ_W-1:0]   fd_num [FQ_W+1];
    logic [FQ_W-1:0]   fd_q   [FQ_W+1];
    logic [TP-1:0]     fd_pay [FQ_W+1];
    tag_t              fd_tag;

    always_comb begin
        r_root  = sq_res[SQ_STEPS][H_W-1:0];
        sq_out  = mtag_t'(sq_pay[SQ_STEPS]);
        u_sq    = ud_q[U_W] * ud_q[U_W];
        cq_sq   = hn_p[6] * hn_p[6];
        cq2_sq  = cq2_reg * cq2_reg;
        fs_prod = f_reg * SIGMA_Q30;
        ma_prod = payq3_reg.mass * a_reg;
    end

    // zero and saturate flags merged into the travelling tags
    always_comb begin
        tag3_next          = tag2_reg;
        tag3_next.zero     = tag2_reg.zero | far;
        pay4_next.mass     = m3_reg;
        pay4_next.tag      = tag3_reg;
        pay4_next.tag.zero = tag3_reg.zero | (d2_sum >= {1'b0, hh_reg})
                           | (khq_reg == '0);
        pay5_next          = sq_out;
        pay5_next.tag.zero = sq_out.tag.zero | (KHQ_W'(r_root) >= khq_reg);
        tagq5_next         = payq4_reg.tag;
        tagq5_next.sat     = KHQ2_W'(num_reg[NUM_W-1:FQ_W]) >= khq2_reg;
    end

    // valid bits of the glue stages
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
            v3_reg  <= 1'b0;
            v4_reg  <= 1'b0;
            v5_reg  <= 1'b0;
            v6_reg  <= 1'b0;
            vq1_reg <= 1'b0;
            vq2_reg <= 1'b0;
            vq3_reg <= 1'b0;
            vq4_reg <= 1'b0;
            vq5_reg <= 1'b0;
        end else if (adv) begin
            v1_reg  <= issue;
            v2_reg  <= v1_reg;
            v3_reg  <= v2_reg;
            v4_reg  <= v3_reg;
            v5_reg  <= sq_v[SQ_STEPS];
            v6_reg  <= ud_v[U_W];
            vq1_reg <= hn_v[6];
            vq2_reg <= vq1_reg;
            vq3_reg <= vq2_reg;
            vq4_reg <= vq3_reg;
            vq5_reg <= vq4_reg;
        end
    end

    // payload of the glue stages
    always_ff @(posedge aclk) begin
        if (adv) begin
            tag1_reg <= tag_issue;

            adx2_reg <= adx;
            ady2_reg <= ady;
            m2_reg   <= rdj[2*POS_W+MASS_W-1:2*POS_W];
            tag2_reg <= tag1_reg;

            dx2_3_reg <= adx2_reg[H_W-1:0] * adx2_reg[H_W-1:0];
            dy2_3_reg <= ady2_reg[H_W-1:0] * ady2_reg[H_W-1:0];
            m3_reg    <= m2_reg;
            tag3_reg  <= tag3_next;

            d2_4_reg <= d2_sum[D2_W-1:0];
            pay4_reg <= pay4_next;

            rem5_reg <= KHQ_W'(r_root);
            pay5_reg <= pay5_next;

            t2_6_reg <= u_sq[2*U_W-1:2];
            pay6_reg <= mtag_t'(ud_pay[U_W]);

            cq2_reg   <= cq_sq[60:30];
            payq1_reg <= mtag_t'(hn_pay[6]);

            f_reg     <= {cq2_sq[60:30], 3'b000};
            payq2_reg <= payq1_reg;

            a_reg     <= fs_prod[60:30];
            payq3_reg <= payq2_reg;

            num_reg   <= {ma_prod, 2'b00};
            payq4_reg <= payq3_reg;

            fd_rem0_reg <= KHQ2_W'(num_reg[NUM_W-1:FQ_W]);
            fd_num0_reg <= num_reg[FQ_W-1:0];
            tagq5_reg   <= tagq5_next;
        end
    end

    // square root cells
    assign sq_v[0]   = v4_reg;
    assign sq_val[0] = d2_4_reg;
    assign sq_res[0] = '0;
    assign sq_pay[0] = pay4_reg;

    for (genvar g = 0; g < SQ_STEPS; g++) begin : g_sqrt
        sdc_sqrt_cell #(.VW(D2_W), .SHIFT(2 * (SQ_STEPS - 1 - g)), .PW(MP)) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (adv),
            .in_vld  (sq_v[g]),
            .in_val  (sq_val[g]),
            .in_res  (sq_res[g]),
            .in_pay  (sq_pay[g]),
            .out_vld (sq_v[g+1]),
            .out_val (sq_val[g+1]),
            .out_res (sq_res[g+1]),
            .out_pay (sq_pay[g+1])
        );
    end

    // u = r / khq cells
    assign ud_v[0]   = v5_reg;
    assign ud_rem[0] = rem5_reg;
    assign ud_num[0] = '0;
    assign ud_q[0]   = '0;
    assign ud_pay[0] = pay5_reg;

    for (genvar g = 0; g < U_W; g++) begin : g_udiv
        sdc_div_cell #(.DW(KHQ_W), .NW(U_W), .QW(U_W), .PW(MP)) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (adv),
            .divisor (khq_reg),
            .in_vld  (ud_v[g]),
            .in_rem  (ud_rem[g]),
            .in_num  (ud_num[g]),
            .in_q    (ud_q[g]),
            .in_pay  (ud_pay[g]),
            .out_vld (ud_v[g+1]),
            .out_rem (ud_rem[g+1]),
            .out_num (ud_num[g+1]),
            .out_q   (ud_q[g+1]),
            .out_pay (ud_pay[g+1])
        );
    end

    // cosine series cells
    assign hn_v[0]   = v6_reg;
    assign hn_p[0]   = COS_C6;
    assign hn_t2[0]  = t2_6_reg;
    assign hn_pay[0] = pay6_reg;

    for (genvar g = 0; g < 6; g++) begin : g_horner
        sdc_horner_cell #(.COEF(HN_COEF[g]), .PW(MP)) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (adv),
            .in_vld  (hn_v[g]),
            .in_p    (hn_p[g]),
            .in_t2   (hn_t2[g]),
            .in_pay  (hn_pay[g]),
            .out_vld (hn_v[g+1]),
            .out_p   (hn_p[g+1]),
            .out_t2  (hn_t2[g+1]),
            .out_pay (hn_pay[g+1])
        );
    end

    // mass * kernel / khq^2 cells
    assign fd_v[0]   = vq5_reg;
    assign fd_rem[0] = fd_rem0_reg;
    assign fd_num[0] = fd_num0_reg;
    assign fd_q[0]   = '0;
    assign fd_pay[0] = tagq5_reg;

    for (genvar g = 0; g < FQ_W; g++) begin : g_fdiv
        sdc_div_cell #(.DW(KHQ2_W), .NW(FQ_W), .QW(FQ_W), .PW(TP)) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (adv),
            .divisor (khq2_reg),
            .in_vld  (fd_v[g]),
            .in_rem  (fd_rem[g]),
            .in_num  (fd_num[g]),
            .in_q    (fd_q[g]),
            .in_pay  (fd_pay[g]),
            .out_vld (fd_v[g+1]),
            .out_rem (fd_rem[g+1]),
            .out_num (fd_num[g+1]),
            .out_q   (fd_q[g+1]),
            .out_pay (fd_pay[g+1])
        );
    end

    // saturating accumulation and result register
    logic [FQ_W-1:0]   contrib;
    logic [DENS_W+1:0] sum_wide;
    logic [DENS_W-1:0] sum_sat;
    logic [DENS_W-1:0] acc_reg;
    logic              m_valid_reg;
    logic [IDX_W-1:0]  m_idx_reg;
    logic [DENS_W-1:0] m_dens_reg;
    logic              m_last_reg;

    always_comb begin
        fd_tag   = tag_t'(fd_pay[FQ_W]);
        contrib  = fd_tag.zero ? '0 : (fd_tag.sat ? {1'b1, {DENS_W{1'b0}}} : fd_q[FQ_W]);
        sum_wide = (DENS_W+2)'(acc_reg) + (DENS_W+2)'(contrib);
        sum_sat  = (sum_wide > (DENS_W+2)'(DENS_MAX)) ? DENS_MAX : sum_wide[DENS_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= fd_v[FQ_W] && fd_tag.rowend;
            if (fd_v[FQ_W]) begin
                acc_reg <= fd_tag.rowend ? '0 : sum_sat;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv && fd_v[FQ_W] && fd_tag.rowend) begin
            m_idx_reg  <= fd_tag.idx;
            m_dens_reg <= sum_sat;
            m_last_reg <= fd_tag.lastrow;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(M_DATA_W-IDX_W-DENS_W){1'b0}}, m_dens_reg, m_idx_reg};
    assign m_tlast  = m_last_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/sdc_checker.sv -----
// port level checks of the density block, bound to the top level
`default_nettype none

`include "sph_density_double_cosine_macros.svh"

module sdc_checker
    import sdc_pkg::*;
(
    input wire logic                  aclk,
    input wire logic                  aresetn,
    input wire logic                  cfg_wr_en,
    input wire logic [CFG_IDX_W-1:0]  cfg_index,
    input wire logic [CFG_DATA_W-1:0] cfg_wdata,
    input wire logic                  s_tvalid,
    input wire logic                  s_tready,
    input wire logic [S_DATA_W-1:0]   s_tdata,
    input wire logic                  s_tlast,
    input wire logic                  m_tvalid,
    input wire logic                  m_tready,
    input wire logic [M_DATA_W-1:0]   m_tdata,
    input wire logic                  m_tlast
);

    // a stalled result holds its payload
    `SDC_ASSERT(a_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast), "result changed while stalled")

    // no loading while results are pending
    `SDC_ASSERT(a_excl, !(m_tvalid && s_tready), "load open while a result is pending")

    // no result straight after a reset cycle
    `SDC_ASSERT_ALWAYS(a_rst, !aresetn |=> !m_tvalid, "result valid after reset")

    // the request marked last closes loading
    `SDC_ASSERT(a_start, s_tvalid && s_tready && s_tlast |=> !s_tready, "loading still open after last request")

    // the final result reopens loading
    `SDC_ASSERT(a_done, m_tvalid && m_tready && m_tlast |=> s_tready && !m_tvalid, "set not closed after final result")

endmodule

bind sph_density_double_cosine sdc_checker u_sdc_checker (.*);

`default_nettype wire

// ----- tb/tb.sv -----
// testbench for the double-cosine density block: queued stimulus, predictor, checker
`timescale 1ns / 100ps
`default_nettype none

module tb;
    import sdc_pkg::*;

    typedef struct {
        logic [POS_W-1:0]  x;
        logic [POS_W-1:0]  y;
        logic [MASS_W-1:0] m;
        logic              last;
    } particle_t;

    typedef struct {
        logic [IDX_W-1:0]  idx;
        logic [DENS_W-1:0] dens;
        logic              last;
    } density_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [S_DATA_W-1:0] s_tdata = '0;
    logic s_tlast = 1'b0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;
    logic m_tlast;

    sph_density_double_cosine dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
    );

    // pending particles, expected densities, predictor state
    particle_t pending[$];
    density_t  dens_expected[$];
    logic [POS_W-1:0]  xs[MAX_PARTICLES_DEF];
    logic [POS_W-1:0]  ys[MAX_PARTICLES_DEF];
    logic [MASS_W-1:0] ms[MAX_PARTICLES_DEF];
    int unsigned n_loaded = 0;
    logic [H_W-1:0] radius = H_RESET;
    logic [K_W-1:0] support = K_RESET;
    int errors = 0;
    int n_items = 0;
    int n_checked = 0;
    int n_sets = 0;
    bit calm = 1'b0;
    int long_req = 0;
    int long_done = 0;

    initial begin
        forever #4 aclk = ~aclk;
    end

    initial begin
        #20000000;
        $display("tb: errors");
        $finish;
    end

    // ---------------- predictor ----------------
    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic longint unsigned horner(longint unsigned c, longint unsigned p,
                                               longint unsigned t2);
        longint unsigned s;
        s = (p * t2) >> 30;
        return (s > c) ? 64'd0 : c - s;
    endfunction

    // cos(pi u / 2) in Q1.30
    function automatic longint unsigned quarter_cos(longint unsigned u);
        longint unsigned t30, t2, p;
        t30 = u << 14;
        t2 = (t30 * t30) >> 30;
        p = COS_C6;
        p = horner(COS_C5, p, t2);
        p = horner(COS_C4, p, t2);
        p = horner(COS_C3, p, t2);
        p = horner(COS_C2, p, t2);
        p = horner(COS_C1, p, t2);
        return horner(Q30_ONE, p, t2);
    endfunction

    function automatic longint unsigned abs_gap(logic [POS_W-1:0] a, logic [POS_W-1:0] b);
        longint d;
        d = longint'($signed(a)) - longint'($signed(b));
        return (d < 0) ? longint'(-d) : longint'(d);
    endfunction

    function automatic longint unsigned pair_contribution(int i, int j, longint unsigned khq);
        longint unsigned h, dx, dy, d2, r, u, cq, cq2, f, a;
        h = radius;
        dx = abs_gap(xs[i], xs[j]);
        dy = abs_gap(ys[i], ys[j]);
        if (dx >= h || dy >= h) return 0;
        d2 = dx * dx + dy * dy;
        if (d2 >= h * h || khq == 0) return 0;
        r = int_sqrt(d2);
        u = (r << 16) / khq;
        if (u >= 65536) return 0;
        cq = quarter_cos(u);
        cq2 = (cq * cq) >> 30;
        f = 8 * ((cq2 * cq2) >> 30);
        a = (f * SIGMA_Q30) >> 30;
        return (longint'(ms[j]) * a * 4) / (khq * khq);
    endfunction

    // store a particle; on the last one queue a density per stored particle
    task automatic predict_densities(particle_t p);
        longint unsigned khq, sum;
        density_t d;
        if (n_loaded < MAX_PARTICLES_DEF) begin
            xs[n_loaded] = p.x;
            ys[n_loaded] = p.y;
            ms[n_loaded] = p.m;
            n_loaded++;
        end
        if (p.last) begin
            khq = (longint'(support) * longint'(radius)) >> 16;
            for (int i = 0; i < n_loaded; i++) begin
                sum = 0;
                for (int j = 0; j < n_loaded; j++) begin
                    if (j != i) begin
                        sum += pair_contribution(i, j, khq);
                        if (sum > DENS_MAX) sum = DENS_MAX;
                    end
                end
                d.idx = i[IDX_W-1:0];
                d.dens = sum[DENS_W-1:0];
                d.last = (i + 1 == n_loaded);
                dens_expected = {dens_expected, d};
            end
            n_loaded = 0;
        end
    endtask

    // ---------------- driver ----------------
    int send_gap = 0;
    always @(posedge aclk) begin
        particle_t p;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!(s_tvalid && !s_tready)) begin
            if (s_tvalid) predict_densities('{s_tdata[31:0], s_tdata[63:32], s_tdata[87:64],
                                               s_tlast});
            if (send_gap > 0) begin
                s_tvalid <= 1'b0;
                send_gap <= send_gap - 1;
            end else if (pending.size() > 0) begin
                p = pending.pop_front();
                s_tdata <= {p.m, p.y, p.x};
                s_tlast <= p.last;
                s_tvalid <= 1'b1;
                send_gap <= calm ? 0 : $urandom_range(0, 14);
                n_items++;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // ---------------- monitor and receiver ----------------
    int recv_wait = 0;
    int long_cnt = 0;
    always @(posedge aclk) begin
        density_t e;
        int w;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                n_checked++;
                if (dens_expected.size() == 0) begin
                    $display("%0t: unexpected density, actual idx=%0d dens=%h last=%b",
                             $time, m_tdata[5:0], m_tdata[37:6], m_tlast);
                    errors++;
                end else begin
                    e = dens_expected.pop_front();
                    if (e.idx !== m_tdata[5:0] || e.dens !== m_tdata[37:6]
                            || e.last !== m_tlast) begin
                        $display("%0t: mismatch, expected idx=%0d dens=%h last=%b, actual idx=%0d dens=%h last=%b",
                                 $time, e.idx, e.dens, e.last, m_tdata[5:0], m_tdata[37:6],
                                 m_tlast);
                        errors++;
                    end
                end
            end
            if (long_req > long_done) begin
                long_cnt <= 600;
                long_done <= long_done + 1;
                m_tready <= 1'b0;
            end else if (long_cnt > 0) begin
                long_cnt <= long_cnt - 1;
                m_tready <= (long_cnt == 1);
            end else if (m_tvalid && m_tready) begin
                w = calm ? 0 : $urandom_range(0, 14);
                recv_wait <= w;
                m_tready <= (w == 0);
            end else if (recv_wait > 0) begin
                recv_wait <= recv_wait - 1;
                m_tready <= (recv_wait == 1);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // ---------------- stimulus ----------------
    task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx == REG_KERNEL_RADIUS) radius = val[H_W-1:0];
        else support = val[K_W-1:0];
    endtask

    task automatic add(logic [31:0] x, logic [31:0] y, logic [23:0] m, logic last);
        pending = {pending, particle_t'{x, y, m, last}};
    endtask

    // cluster of n particles around a random centre, spread within the radius
    task automatic add_cluster(int n);
        logic [31:0] cx, cy;
        longint span;
        cx = $urandom;
        cy = $urandom;
        span = longint'(radius) * 3 / 4 + 1;
        for (int i = 0; i < n; i++)
            add(cx + 32'(longint'($urandom_range(0, 2 * span)) - span),
                cy + 32'(longint'($urandom_range(0, 2 * span)) - span),
                MASS_W'($urandom), i == n - 1);
        n_sets++;
    endtask

    task automatic settle();
        while (pending.size() != 0 || dens_expected.size() != 0 || s_tvalid)
            @(posedge aclk);
        repeat (120) @(posedge aclk);
    endtask

    int sent;
    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // single particle, coincident pair, far extremes at reset settings
        add(32'h0001_0000, 32'h0002_0000, 24'hFFFFFF, 1'b1);
        add(32'h0, 32'h0, 24'hFFFFFF, 1'b0);
        add(32'h0, 32'h0, 24'hFFFFFF, 1'b1);
        add(32'h8000_0000, 32'h7FFF_FFFF, 24'h0, 1'b0);
        add(32'h7FFF_FFFF, 32'h8000_0000, 24'hFFFFFF, 1'b0);
        add(32'h8000_0000, 32'h7FFF_FFFF, 24'hFFFFFF, 1'b0);
        add(32'h7FFF_FFFF, 32'h8000_0000, 24'h0, 1'b1);
        n_sets += 3;
        add_cluster(5);
        settle();

        // smallest radius, support 65536: coincident heavy particles saturate
        write_reg(REG_KERNEL_RADIUS, 24'd1);
        write_reg(REG_COS_SUPPORT, 24'd65536);
        for (int i = 0; i < 4; i++) add(32'h1234_5678, 32'hFEDC_BA98, 24'hFFFFFF, i == 3);
        n_sets++;
        settle();

        // largest settings, more particles than the store holds, long result hold-off
        write_reg(REG_KERNEL_RADIUS, 24'hFFFFFF);
        write_reg(REG_COS_SUPPORT, 24'hFFFFF);
        calm = 1'b1;
        long_req = 1;
        add_cluster(66);
        add_cluster(6);
        settle();
        calm = 1'b0;

        // random settings and clusters
        sent = n_items;
        while (n_items - sent < 50) begin
            write_reg(REG_KERNEL_RADIUS,
                      CFG_DATA_W'($urandom_range(1, 24'hFFFFFF) >> $urandom_range(0, 8)));
            write_reg(REG_COS_SUPPORT, CFG_DATA_W'($urandom_range(65536, 1048575)));
            calm = ($urandom_range(0, 3) == 0);
            for (int s = $urandom_range(1, 3); s > 0; s--) add_cluster($urandom_range(2, 12));
            settle();
        end

        $display("tb: %0d particles in %0d sets sent, %0d densities checked",
                 n_items, n_sets, n_checked);
        if (errors == 0) $display("tb: clean");
        else $display("tb: errors");
        $finish;
    end

endmodule

`default_nettype wire
